@@ rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk outside reset.
`define CHK_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition leads to another in the next cycle.
`define CHK_NEXT(lbl, cond, res, msg) \
    `CHK_ASSERT(lbl, (cond) |=> (res), msg)

`endif

@@ rtl/lrus_pkg.sv @@
// ---------------------------------------------------------------------------
// LRU shift estimate package
// Shared constants, opcodes, control types and the rounded mean function.
// ---------------------------------------------------------------------------
package lrus_pkg;

    localparam int DEF_NUM_SETS = 2048;
    localparam int DEF_NUM_WAYS = 16;
    localparam int SET_IDX_W    = 11;
    localparam int WAY_IDX_W    = 5;
    localparam int STAMP_W      = 64;
    localparam int HIST_DEPTH   = 5;
    localparam int SUM_W        = 9;
    localparam int MEAN_W       = 6;
    localparam int DIST_W       = 4;
    localparam int RECIP_MUL    = 205;
    localparam int RECIP_SHIFT  = 11;

    typedef enum logic [1:0] {
        OP_VICTIM = 2'd0,
        OP_FILL   = 2'd1,
        OP_UPDATE = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef struct packed {
        logic clr;
        logic rd;
        logic wr;
    } hist_ctrl_t;

    // (2*sum+5) div 10, the divide done as a multiply by 205/2048
    function automatic logic [MEAN_W-1:0] mean_of_five(input logic [SUM_W-1:0] sum);
        logic [SUM_W:0]   num;
        logic [SUM_W+8:0] prod;
        num  = {sum, 1'b0} + (SUM_W+1)'(5);
        prod = (SUM_W+9)'(num) * (SUM_W+9)'(RECIP_MUL);
        return prod[RECIP_SHIFT +: MEAN_W];
    endfunction

endpackage

@@ rtl/lru_replacement_with_shift_estimate_unit.sv @@
// ---------------------------------------------------------------------------
// Timestamp LRU replacement with shift estimate
// Way stamps in one synchronous memory scanned for the oldest way; per-set
// way history in a second memory feeding the shift distance estimate.
//
//   channel  signals                                         direction
//   in       in_valid/in_ready, op, set_index, way_index,    into block
//            hit_flag, is_writeback
//   out      out_valid/out_ready, victim_way, shift_distance out of block
//
// Fill, unused op, bypass update and out-of-range set finish when accepted.
// Update: history read, then write back. Victim: one stamp read per way from
// the single stamp memory port. After reset a clearing pass over all
// NUM_SETS*2**clog2(NUM_WAYS) stamp addresses (32768 by default) zeroes the
// stamps and presets the history; in_ready stays low. One item in flight; a
// finished word meeting a full output register waits in a holding register.
// ---------------------------------------------------------------------------
module lru_replacement_with_shift_estimate_unit
    import lrus_pkg::*;
#(
    parameter int NUM_SETS = DEF_NUM_SETS,
    parameter int NUM_WAYS = DEF_NUM_WAYS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           op,
    input  logic [SET_IDX_W-1:0] set_index,
    input  logic [WAY_IDX_W-1:0] way_index,
    input  logic                 hit_flag,
    input  logic                 is_writeback,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [3:0]           victim_way,
    output logic [DIST_W-1:0]    shift_distance
);

    localparam int SET_W       = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int WAY_W       = $clog2(NUM_WAYS);
    localparam int SA_W        = SET_W + WAY_W;
    localparam int STAMP_DEPTH = NUM_SETS * (2 ** WAY_W);
    localparam int SCAN_W      = WAY_W + 1;
    localparam int SETCMP_W    = SET_IDX_W + 2;
    localparam int WAYCMP_W    = 7;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_HIST,
        ST_DONE
    } state_t;

    state_t              state_reg;
    logic [SA_W-1:0]     clr_reg;
    logic [STAMP_W-1:0]  counter_reg;
    logic [DIST_W-1:0]   last_dist_reg;
    logic                out_valid_reg;
    logic [3:0]          victim_out_reg;
    logic [DIST_W-1:0]   dist_out_reg;
    logic [WAY_W-1:0]    res_victim_reg;

    logic [SET_W-1:0]    set_reg;
    logic [WAY_W-1:0]    way_reg;
    logic [SCAN_W-1:0]   scan_reg;
    logic [STAMP_W-1:0]  best_stamp_reg;
    logic [WAY_W-1:0]    best_way_reg;
    logic [STAMP_W-1:0]  stamp_rd_reg;
    logic [STAMP_W-1:0]  stamp_mem [STAMP_DEPTH];

    op_t                 op_in;
    logic                in_acc;
    logic                set_ok;
    logic                way_ok;
    logic                go_scan;
    logic                go_hist;
    logic                do_stamp;
    logic [SET_W-1:0]    set_in;
    logic [WAY_W-1:0]    way_in;
    logic                out_free;
    logic                clr_done;
    logic                scan_rd;
    logic                scan_first;
    logic                scan_less;
    logic [WAY_W-1:0]    cmp_way;
    logic                fin;
    logic [WAY_W-1:0]    fin_victim;
    logic [DIST_W-1:0]   fin_dist;
    hist_ctrl_t          hist_ctrl;
    logic [SET_W-1:0]    hist_addr;
    logic [DIST_W-1:0]   hist_dist;

    assign in_ready       = (state_reg == ST_IDLE);
    assign out_valid      = out_valid_reg;
    assign victim_way     = victim_out_reg;
    assign shift_distance = dist_out_reg;

    assign op_in    = op_t'(op);
    assign in_acc   = in_valid && in_ready;
    assign set_ok   = SETCMP_W'(set_index) < SETCMP_W'(NUM_SETS);
    assign way_ok   = WAYCMP_W'(way_index) < WAYCMP_W'(NUM_WAYS);
    assign set_in   = SET_W'(set_index);
    assign way_in   = WAY_W'(way_index);
    assign go_scan  = (op_in == OP_VICTIM) && set_ok;
    assign go_hist  = (op_in == OP_UPDATE) && set_ok && way_ok;
    assign do_stamp = in_acc && set_ok && way_ok &&
                      ((op_in == OP_FILL) ||
                       ((op_in == OP_UPDATE) && hit_flag && !is_writeback));
    assign out_free = !out_valid_reg || out_ready;
    assign clr_done = (clr_reg == SA_W'(STAMP_DEPTH - 1));

    assign scan_rd    = (state_reg == ST_SCAN) && (scan_reg < SCAN_W'(NUM_WAYS));
    assign scan_first = (scan_reg == SCAN_W'(1));
    assign scan_less  = stamp_rd_reg < best_stamp_reg;
    assign cmp_way    = WAY_W'(scan_reg - SCAN_W'(1));

    assign hist_ctrl.clr = (state_reg == ST_CLEAR) &&
                           ((SA_W+1)'(clr_reg) < (SA_W+1)'(NUM_SETS));
    assign hist_ctrl.rd  = in_acc && go_hist;
    assign hist_ctrl.wr  = (state_reg == ST_HIST);

    always_comb
    begin
        priority if (state_reg == ST_CLEAR)
        begin
            hist_addr = clr_reg[SET_W-1:0];
        end
        else if (state_reg == ST_IDLE)
        begin
            hist_addr = set_in;
        end
        else
        begin
            hist_addr = set_reg;
        end
    end

    lrus_hist #(
        .NUM_SETS (NUM_SETS),
        .NUM_WAYS (NUM_WAYS)
    ) u_hist (
        .clk        (clk),
        .ctrl       (hist_ctrl),
        .addr       (hist_addr),
        .way        (way_reg),
        .shift_dist (hist_dist)
    );

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_CLEAR)
        begin
            stamp_mem[clr_reg] <= '0;
        end
        else if (do_stamp)
        begin
            stamp_mem[{set_in, way_in}] <= counter_reg;
        end
        if (scan_rd)
        begin
            stamp_rd_reg <= stamp_mem[{set_reg, scan_reg[WAY_W-1:0]}];
        end
    end

    always_comb
    begin
        fin        = 1'b0;
        fin_victim = '0;
        fin_dist   = last_dist_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                fin = in_acc && !go_scan && !go_hist;
            end
            ST_SCAN:
            begin
                if (scan_reg == SCAN_W'(NUM_WAYS))
                begin
                    fin        = 1'b1;
                    fin_victim = scan_less ? cmp_way : best_way_reg;
                end
            end
            ST_HIST:
            begin
                fin      = 1'b1;
                fin_dist = hist_dist;
            end
            default:
            begin
                fin = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            set_reg  <= set_in;
            way_reg  <= way_in;
            scan_reg <= '0;
        end
        else if (state_reg == ST_SCAN)
        begin
            scan_reg <= scan_reg + SCAN_W'(1);
        end
        if ((state_reg == ST_SCAN) && (scan_reg != '0) && (scan_first || scan_less))
        begin
            best_stamp_reg <= stamp_rd_reg;
            best_way_reg   <= cmp_way;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_reg        <= '0;
            counter_reg    <= '0;
            last_dist_reg  <= '0;
            out_valid_reg  <= 1'b0;
            victim_out_reg <= '0;
            dist_out_reg   <= '0;
            res_victim_reg <= '0;
        end
        else
        begin
            if (do_stamp)
            begin
                counter_reg <= counter_reg + STAMP_W'(1);
            end
            if (out_free && (fin || (state_reg == ST_DONE)))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (fin)
            begin
                last_dist_reg <= fin_dist;
                if (out_free)
                begin
                    victim_out_reg <= 4'(fin_victim);
                    dist_out_reg   <= fin_dist;
                end
                else
                begin
                    res_victim_reg <= fin_victim;
                end
            end
            unique case (state_reg)
                ST_CLEAR:
                begin
                    clr_reg <= clr_reg + SA_W'(1);
                    if (clr_done)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (in_acc)
                    begin
                        priority if (go_scan)
                        begin
                            state_reg <= ST_SCAN;
                        end
                        else if (go_hist)
                        begin
                            state_reg <= ST_HIST;
                        end
                        else if (!out_free)
                        begin
                            state_reg <= ST_DONE;
                        end
                    end
                end
                ST_SCAN, ST_HIST:
                begin
                    if (fin)
                    begin
                        state_reg <= out_free ? ST_IDLE : ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        victim_out_reg <= 4'(res_victim_reg);
                        dist_out_reg   <= last_dist_reg;
                        state_reg      <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

@@ rtl/lrus_hist.sv @@
// ---------------------------------------------------------------------------
// LRU shift estimate history unit
// Per-set history of recent ways in a synchronous memory, with the shift
// distance between a new way and the rounded mean of the previous five.
// ---------------------------------------------------------------------------
module lrus_hist
    import lrus_pkg::*;
#(
    parameter int NUM_SETS = DEF_NUM_SETS,
    parameter int NUM_WAYS = DEF_NUM_WAYS,
    localparam int SET_W = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1,
    localparam int WAY_W = $clog2(NUM_WAYS)
)
(
    input  logic              clk,
    input  hist_ctrl_t        ctrl,
    input  logic [SET_W-1:0]  addr,
    input  logic [WAY_W-1:0]  way,
    output logic [DIST_W-1:0] shift_dist
);

    localparam int ROW_W    = HIST_DEPTH * WAY_W;
    localparam int DIST_MAX = (1 << DIST_W) - 1;
    localparam logic [ROW_W-1:0] RESET_ROW = {HIST_DEPTH{WAY_W'(NUM_WAYS - 1)}};

    logic [ROW_W-1:0]  hist_mem [NUM_SETS];
    logic [ROW_W-1:0]  row_reg;
    logic [SUM_W-1:0]  sum;
    logic [MEAN_W-1:0] mean;
    logic [MEAN_W:0]   way_x;
    logic [MEAN_W:0]   mean_x;
    logic [MEAN_W:0]   diff;

    always_ff @(posedge clk)
    begin
        if (ctrl.clr)
        begin
            hist_mem[addr] <= RESET_ROW;
        end
        else if (ctrl.wr)
        begin
            hist_mem[addr] <= {row_reg[ROW_W-WAY_W-1:0], way};
        end
        if (ctrl.rd)
        begin
            row_reg <= hist_mem[addr];
        end
    end

    always_comb
    begin
        sum = '0;
        for (int i = 0; i < HIST_DEPTH; i++)
        begin
            sum = sum + SUM_W'(row_reg[i*WAY_W +: WAY_W]);
        end
        mean       = mean_of_five(sum);
        way_x      = (MEAN_W+1)'(way);
        mean_x     = (MEAN_W+1)'(mean);
        diff       = (way_x >= mean_x) ? (way_x - mean_x) : (mean_x - way_x);
        shift_dist = (diff > (MEAN_W+1)'(DIST_MAX)) ? DIST_W'(DIST_MAX) : diff[DIST_W-1:0];
    end

endmodule

@@ rtl/lrus_checker.sv @@
// ---------------------------------------------------------------------------
// LRU shift estimate port checker
// Port-level assertions for the replacement unit, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module lrus_checker
    import lrus_pkg::*;
#(
    parameter int NUM_SETS = DEF_NUM_SETS,
    parameter int NUM_WAYS = DEF_NUM_WAYS
)
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input logic [1:0]           op,
    input logic [SET_IDX_W-1:0] set_index,
    input logic                 out_valid,
    input logic                 out_ready,
    input logic [3:0]           victim_way,
    input logic [DIST_W-1:0]    shift_distance
);

    `CHK_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(victim_way) && $stable(shift_distance), "output word dropped or changed while stalled")
    `CHK_ASSERT(a_victim_range, out_valid |-> ((NUM_WAYS > 16) || (32'(victim_way) < NUM_WAYS)), "victim way out of range")
    `CHK_NEXT(a_quick_done, in_valid && in_ready && (op == OP_FILL || op == OP_NONE), out_valid, "fill or unused op word not produced")
    `CHK_NEXT(a_scan_busy, in_valid && in_ready && op == OP_VICTIM && ((SET_IDX_W+2)'(set_index) < (SET_IDX_W+2)'(NUM_SETS)), !in_ready, "input taken during victim scan")

endmodule

bind lru_replacement_with_shift_estimate_unit lrus_checker #(
    .NUM_SETS (NUM_SETS),
    .NUM_WAYS (NUM_WAYS)
) u_lrus_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .op             (op),
    .set_index      (set_index),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .victim_way     (victim_way),
    .shift_distance (shift_distance)
);

@@ sim/tb.sv @@
// ---------------------------------------------------------------------------
// Testbench for the timestamp LRU replacement unit
// Drives find-victim, fill, update and unused requests through the valid/ready
// input channel, predicts each result word from a behavioral copy of the
// stamps, use counter and per-set way history, and compares every output word
// in order. Both sides pause at random, with some stretches left free of
// pauses.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
    import lrus_pkg::*;

    localparam int NSETS        = DEF_NUM_SETS;
    localparam int NWAYS        = DEF_NUM_WAYS;
    localparam int HIST_LEN     = 6;
    localparam int RANDOM_WORDS = 800;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 400000;

    typedef struct {
        bit [3:0]        victim;
        bit [DIST_W-1:0] distance;
    } lru_result_t;

    class lru_tracker;
        bit [STAMP_W-1:0] stamps [NSETS*NWAYS];
        bit [3:0]         recent [NSETS*HIST_LEN];
        bit [STAMP_W-1:0] use_count;
        bit [DIST_W-1:0]  last_dist;
        lru_result_t      pending [$];
        int               errors;
        int               checked;

        function new();
            foreach (stamps[i])
                stamps[i] = '0;
            foreach (recent[i])
                recent[i] = 4'(NWAYS - 1);
            use_count = '0;
            last_dist = '0;
            errors    = 0;
            checked   = 0;
        endfunction

        function void note_request(op_t code, int unsigned set, int unsigned way,
                                   bit hit, bit wb);
            lru_result_t      r;
            int unsigned      best;
            bit [STAMP_W-1:0] best_stamp;
            int unsigned      sum;
            int unsigned      mean;
            int unsigned      distance;
            int unsigned      sbase;
            int unsigned      hbase;
            r.victim = '0;
            sbase    = set * NWAYS;
            hbase    = set * HIST_LEN;
            if (set < NSETS)
            begin
                case (code)
                    OP_VICTIM:
                    begin
                        best       = 0;
                        best_stamp = stamps[sbase];
                        for (int w = 1; w < NWAYS; w++)
                        begin
                            if (stamps[sbase + w] < best_stamp)
                            begin
                                best_stamp = stamps[sbase + w];
                                best       = w;
                            end
                        end
                        r.victim = 4'(best);
                    end
                    OP_FILL:
                    begin
                        if (way < NWAYS)
                        begin
                            stamps[sbase + way] = use_count;
                            use_count           = use_count + 1;
                        end
                    end
                    OP_UPDATE:
                    begin
                        if (way < NWAYS)
                        begin
                            if (hit && !wb)
                            begin
                                stamps[sbase + way] = use_count;
                                use_count           = use_count + 1;
                            end
                            for (int i = HIST_LEN - 1; i > 0; i--)
                                recent[hbase + i] = recent[hbase + i - 1];
                            recent[hbase] = 4'(way);
                            sum = 0;
                            for (int i = 1; i <= 5; i++)
                                sum += recent[hbase + i];
                            mean = (2 * sum + 5) / 10;
                            distance = (way >= mean) ? way - mean : mean - way;
                            if (distance > 15)
                                distance = 15;
                            last_dist = DIST_W'(distance);
                        end
                    end
                    default: ;
                endcase
            end
            r.distance = last_dist;
            pending.insert(pending.size(), r);
        endfunction

        function void check_result(bit [3:0] victim, bit [DIST_W-1:0] distance);
            lru_result_t want;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected word victim_way=%0d shift_distance=%0d",
                         $time, victim, distance);
                errors++;
                return;
            end
            want = pending.pop_front();
            checked++;
            if (victim !== want.victim)
            begin
                $display("%0t: victim_way mismatch expected %0d actual %0d",
                         $time, want.victim, victim);
                errors++;
            end
            if (distance !== want.distance)
            begin
                $display("%0t: shift_distance mismatch expected %0d actual %0d",
                         $time, want.distance, distance);
                errors++;
            end
        endfunction
    endclass

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 in_valid     = 1'b0;
    logic                 in_ready;
    logic [1:0]           op           = OP_NONE;
    logic [SET_IDX_W-1:0] set_index    = '0;
    logic [WAY_IDX_W-1:0] way_index    = '0;
    logic                 hit_flag     = 1'b0;
    logic                 is_writeback = 1'b0;
    logic                 out_valid;
    logic                 out_ready    = 1'b0;
    logic [3:0]           victim_way;
    logic [DIST_W-1:0]    shift_distance;

    lru_tracker           tracker;
    bit                   quiet        = 1'b0;
    int                   cycles       = 0;
    int                   op_count [4] = '{0, 0, 0, 0};
    bit [SET_IDX_W-1:0]   hot_sets [4];

    lru_replacement_with_shift_estimate_unit DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .op             (op),
        .set_index      (set_index),
        .way_index      (way_index),
        .hit_flag       (hit_flag),
        .is_writeback   (is_writeback),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .victim_way     (victim_way),
        .shift_distance (shift_distance)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("tb: FAIL");
            $finish;
        end
    end

    function automatic int draw_gap();
        return quiet ? 0 : $urandom_range(0, 9);
    endfunction

    task automatic send_word(op_t code, bit [SET_IDX_W-1:0] set, bit [WAY_IDX_W-1:0] way,
                             bit hit, bit wb);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        op           = code;
        set_index    = set;
        way_index    = way;
        hit_flag     = hit;
        is_writeback = wb;
        in_valid     = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        tracker.note_request(code, set, way, hit, wb);
        op_count[code]++;
        @(negedge clk);
    endtask

    task automatic random_word();
        int unsigned          pick;
        op_t                  code;
        bit [SET_IDX_W-1:0]   set;
        bit [WAY_IDX_W-1:0]   way;
        pick = $urandom_range(0, 99);
        if (pick < 30)
            code = OP_VICTIM;
        else if (pick < 55)
            code = OP_FILL;
        else if (pick < 95)
            code = OP_UPDATE;
        else
            code = OP_NONE;
        if ($urandom_range(0, 9) < 7)
            set = hot_sets[$urandom_range(0, 3)];
        else
            set = SET_IDX_W'($urandom_range(0, NSETS - 1));
        if ($urandom_range(0, 6) == 0)
            way = WAY_IDX_W'($urandom_range(16, 31));
        else
            way = WAY_IDX_W'($urandom_range(0, NWAYS - 1));
        send_word(code, set, way, $urandom_range(0, 3) != 0, $urandom_range(0, 4) == 0);
    endtask

    initial
    begin : result_side
        int stall;
        @(posedge rst_n);
        forever
        begin
            stall = draw_gap();
            if (stall > 0)
            begin
                out_ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready = 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            tracker.check_result(victim_way, shift_distance);
            @(negedge clk);
        end
    end

    initial
    begin : request_side
        tracker = new();
        hot_sets[0] = '0;
        hot_sets[1] = SET_IDX_W'(NSETS - 1);
        hot_sets[2] = SET_IDX_W'($urandom_range(1, NSETS - 2));
        hot_sets[3] = SET_IDX_W'($urandom_range(1, NSETS - 2));
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        send_word(OP_VICTIM, 0, 0, 0, 0);
        send_word(OP_FILL, 0, 0, 0, 0);
        send_word(OP_FILL, 0, 15, 0, 0);
        send_word(OP_FILL, 0, 3, 0, 0);
        send_word(OP_VICTIM, 0, 0, 0, 0);
        send_word(OP_UPDATE, 0, 1, 1, 0);
        send_word(OP_UPDATE, 0, 2, 1, 1);
        send_word(OP_VICTIM, 0, 0, 0, 0);
        send_word(OP_UPDATE, 0, 16, 1, 0);
        send_word(OP_UPDATE, 0, 31, 1, 0);
        send_word(OP_FILL, 0, 16, 0, 0);
        send_word(OP_FILL, 0, 31, 1, 1);
        send_word(OP_NONE, 0, 5, 1, 0);
        send_word(OP_UPDATE, 2047, 15, 0, 0);
        send_word(OP_UPDATE, 2047, 0, 0, 0);
        send_word(OP_UPDATE, 2047, 0, 0, 1);
        send_word(OP_UPDATE, 2047, 0, 1, 1);
        send_word(OP_UPDATE, 2047, 0, 0, 0);
        send_word(OP_UPDATE, 2047, 15, 1, 0);
        send_word(OP_FILL, 2047, 15, 0, 0);
        send_word(OP_VICTIM, 2047, 0, 0, 0);
        send_word(OP_VICTIM, 1024, 0, 0, 0);
        send_word(OP_UPDATE, 1365, 10, 0, 1);
        send_word(OP_NONE, 2047, 31, 0, 1);

        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            if (i % 50 == 0)
                quiet = ($urandom_range(0, 3) == 0);
            random_word();
        end
        in_valid = 1'b0;
        quiet    = 1'b0;

        while (tracker.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d victim, %0d fill, %0d update and %0d unused requests",
                 op_count[OP_VICTIM], op_count[OP_FILL], op_count[OP_UPDATE],
                 op_count[OP_NONE]);
        $display("checked %0d result words, %0d mismatches", tracker.checked,
                 tracker.errors);
        if (tracker.errors == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end
endmodule

@@ files.f @@
+incdir+rtl
rtl/lrus_pkg.sv
rtl/lrus_hist.sv
rtl/lru_replacement_with_shift_estimate_unit.sv
rtl/lrus_checker.sv
sim/tb.sv
